@@ hdl/tssc_pkg.sv @@
// ============================================================================
// tssc_pkg: shared constants and helpers for target_sum_subset_count
// Sizes of the count table, payload widths, register map, count arithmetic.
// ============================================================================
`default_nettype none

package tssc_pkg;

    localparam int SUM_MAX  = 1024;
    localparam int COUNT_W  = 32;
    localparam int VALUE_W  = 10;
    localparam int WAYS_W   = 32;
    localparam int TGT_W    = 12;
    localparam int IDX_W    = $clog2(SUM_MAX + 1);
    localparam int TOT_W    = $clog2(SUM_MAX + 2);
    localparam int DEPTH    = SUM_MAX + 1;

    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    localparam logic [CFG_AW-3:0] REG_TARGET = '0;

    localparam logic [63:0] WAYS_MAX = 64'((65'd1 << WAYS_W) - 65'd1);

    // count add, clamped at all ones
    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
    endfunction

    // count to result width, clamped at all ones
    function automatic logic [WAYS_W-1:0] to_ways(input logic [COUNT_W-1:0] c);
        logic [63:0] c64;
        c64 = 64'(c);
        return (c64 > WAYS_MAX) ? '1 : WAYS_W'(c64);
    endfunction

endpackage

`default_nettype wire

@@ hdl/tssc_if.sv @@
// ============================================================================
// tssc_if: request channels of target_sum_subset_count
// Input channel carries one number per request, output channel one result.
// ============================================================================
`default_nettype none

interface tssc_in_if;
    import tssc_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last;
    modport source (output valid, value, last, input ready);
    modport sink   (input valid, value, last, output ready);
endinterface

interface tssc_out_if;
    import tssc_pkg::*;
    logic              valid;
    logic              ready;
    logic [WAYS_W-1:0] ways;
    logic              overflow;
    modport source (output valid, ways, overflow, input ready);
    modport sink   (input valid, ways, overflow, output ready);
endinterface

`default_nettype wire

@@ hdl/tssc_ram.sv @@
// ============================================================================
// tssc_ram: generic RAM, one write port, two registered read ports
// Holds the subset count table.
// ============================================================================
`default_nettype none

module tssc_ram #(
    parameter int DEPTH = 1025,
    parameter int AW    = 11,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr_a,
    output logic      [DW-1:0] o_rdata_a,
    input  wire logic [AW-1:0] i_raddr_b,
    output logic      [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

@@ hdl/tssc_cfg.sv @@
// ============================================================================
// tssc_cfg: APB register block
// Holds the signed target total.
// ============================================================================
`default_nettype none

module tssc_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [tssc_pkg::CFG_AW-1:0]   i_paddr,
    input  wire logic [tssc_pkg::CFG_DW-1:0]   i_pwdata,
    output logic      [tssc_pkg::CFG_DW-1:0]   o_prdata,
    output logic                               o_pready,
    output logic signed [tssc_pkg::TGT_W-1:0]  o_target
);
    import tssc_pkg::*;

    logic signed [TGT_W-1:0] r_target;
    logic                    w_hit;

    assign w_hit    = (i_paddr[CFG_AW-1:2] == REG_TARGET);
    assign o_pready = 1'b1;
    assign o_target = r_target;
    assign o_prdata = w_hit ? CFG_DW'(r_target) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_psel && i_penable && i_pwrite && w_hit) begin
            r_target <= i_pwdata[TGT_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hdl/tssc_core.sv @@
// ============================================================================
// tssc_core: sweep sequencer around the count table
// One saturating adder updates one table entry per cycle, top index down.
// ============================================================================
`default_nettype none

module tssc_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic signed [tssc_pkg::TGT_W-1:0] i_target,
    tssc_in_if.sink                            i_in,
    tssc_out_if.source                         o_out
);
    import tssc_pkg::*;

    localparam int ACC_W = ((TOT_W > VALUE_W) ? TOT_W : VALUE_W) + 1;
    localparam int D_W   = (IDX_W > VALUE_W) ? IDX_W : VALUE_W;
    localparam int SUM_W = (((TOT_W + 1) > TGT_W) ? (TOT_W + 1) : TGT_W) + 1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SWEEP = 6'b000100,
        S_DRAIN = 6'b001000,
        S_LOOK  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [VALUE_W-1:0] r_v, n_v;
    logic               r_last, n_last;
    logic [TOT_W-1:0]   r_total, n_total;
    logic               r_ovf, n_ovf;
    logic               r_pend, n_pend;
    logic [IDX_W-1:0]   r_wr_addr, n_wr_addr;
    logic               r_ok, n_ok;
    logic               r_out_valid, n_out_valid;
    logic [WAYS_W-1:0]  r_out_ways, n_out_ways;
    logic               r_out_ovf, n_out_ovf;

    logic               w_we;
    logic [IDX_W-1:0]   w_waddr, w_raddr_a, w_raddr_b;
    logic [COUNT_W-1:0] w_wdata, w_rdata_a, w_rdata_b;

    logic [ACC_W-1:0]        w_acc;
    logic                    w_over;
    logic [D_W-1:0]          w_diff;
    logic signed [SUM_W-1:0] s_tot, s_tgt, s_sum, s_half;
    logic                    w_ok;
    logic [IDX_W-1:0]        w_p;

    tssc_ram #(
        .DEPTH (DEPTH),
        .AW    (IDX_W),
        .DW    (COUNT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    assign w_acc  = ACC_W'(r_total) + ACC_W'(i_in.value);
    assign w_over = (w_acc > ACC_W'(SUM_MAX));
    assign w_diff = D_W'(r_j) - D_W'(r_v);

    assign s_tot  = $signed(SUM_W'(r_total));
    assign s_tgt  = SUM_W'(i_target);
    assign s_sum  = s_tot + s_tgt;
    assign s_half = s_sum >>> 1;
    assign w_ok   = !r_ovf && (s_tot >= s_tgt) && !s_sum[SUM_W-1] && !s_sum[0]
                    && (s_half <= $signed(SUM_W'(SUM_MAX)));
    assign w_p    = s_half[IDX_W-1:0];

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.ways     = r_out_ways;
    assign o_out.overflow = r_out_ovf;

    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        n_v         = r_v;
        n_last      = r_last;
        n_total     = r_total;
        n_ovf       = r_ovf;
        n_pend      = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_ok        = r_ok;
        n_out_valid = r_out_valid;
        n_out_ways  = r_out_ways;
        n_out_ovf   = r_out_ovf;
        w_raddr_a   = r_j;
        w_raddr_b   = w_diff[IDX_W-1:0];
        w_we        = 1'b0;
        w_waddr     = r_wr_addr;
        w_wdata     = sat_add(w_rdata_a, w_rdata_b);

        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (r_pend) begin
            w_we = 1'b1;
        end

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = (r_j == '0) ? COUNT_W'(1) : '0;
                if (r_j == IDX_W'(SUM_MAX)) begin
                    n_state = S_IDLE;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_v    = i_in.value;
                    n_last = i_in.last;
                    if (r_ovf) begin
                        n_state = i_in.last ? S_LOOK : S_IDLE;
                    end else if (w_over) begin
                        n_ovf   = 1'b1;
                        n_total = TOT_W'(SUM_MAX + 1);
                        n_state = i_in.last ? S_LOOK : S_IDLE;
                    end else begin
                        n_total = TOT_W'(w_acc);
                        n_j     = IDX_W'(SUM_MAX);
                        n_state = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                n_pend    = 1'b1;
                n_wr_addr = r_j;
                if (D_W'(r_j) == D_W'(r_v)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_j = r_j - 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = r_last ? S_LOOK : S_IDLE;
            end
            S_LOOK: begin
                w_raddr_a = w_p;
                if (!r_out_valid) begin
                    n_ok    = w_ok;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_out_ways  = r_ok ? to_ways(w_rdata_a) : '0;
                n_out_ovf   = r_ovf;
                n_out_valid = 1'b1;
                n_total     = '0;
                n_ovf       = 1'b0;
                n_j         = '0;
                n_state     = S_CLEAR;
            end
            default: begin
                n_state = S_CLEAR;
                n_j     = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_j         <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_j         <= n_j;
            r_total     <= n_total;
            r_ovf       <= n_ovf;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_last     <= n_last;
        r_wr_addr  <= n_wr_addr;
        r_ok       <= n_ok;
        r_out_ways <= n_out_ways;
        r_out_ovf  <= n_out_ovf;
    end

    // table write-back only follows a sweep read
    a_pend_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SWEEP || r_state == S_DRAIN))
        else $error("pending write outside sweep");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TOT_W'(SUM_MAX + 1))
        else $error("running total out of range");

    a_ovf_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_total == TOT_W'(SUM_MAX + 1)))
        else $error("overflow without clamped total");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (D_W'(r_j) >= D_W'(r_v)))
        else $error("sweep index below value");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside emit");

endmodule

`default_nettype wire

@@ hdl/target_sum_subset_count.sv @@
// ============================================================================
// target_sum_subset_count: signed subset-sum way counter
// Counts the +/- sign assignments of a set of numbers that reach a target.
// ============================================================================
// Usage:
//   i_in carries one number per request; last marks the end of a set.
//   o_out carries one result (ways, overflow) per set, on its last number.
//   The APB port holds target_total (signed, 12 bits) at byte address 0;
//   write it only while the block is idle.
// Sequence:
//   A number sweeps the table from index SUM_MAX down to its value, one entry
//   read, added and written back per cycle by the shared adder, bounded by
//   the table RAM's single write port; i_in.ready stays low until the sweep ends.
//   A number after overflow skips the sweep. The last number adds the table
//   lookup, then a clearing pass of all 1025 entries before the next request.
// Reset:
//   Synchronous, active low. Afterwards the same clearing pass
//   runs; i_in.ready stays low until it ends. Target resets to zero.
// Stall:
//   A result waits in the output register; the block keeps taking numbers
//   and holds only when the next result is due before the old one is taken.
// ============================================================================
`default_nettype none

module target_sum_subset_count (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tssc_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [tssc_pkg::CFG_DW-1:0]  pwdata,
    output logic      [tssc_pkg::CFG_DW-1:0]  prdata,
    output logic                              pready,
    tssc_in_if.sink                           i_in,
    tssc_out_if.source                        o_out
);
    import tssc_pkg::*;

    logic signed [TGT_W-1:0] w_target;

    tssc_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_target  (w_target)
    );

    tssc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_target (w_target),
        .i_in     (i_in),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire
